@@ rtl/snappy_block_decompressor_macros.svh @@
// Assertion macros for the Snappy block decompressor.
// No dependencies; included by modules that assert.
`ifndef SNAPPY_BLOCK_DECOMPRESSOR_MACROS_SVH
`define SNAPPY_BLOCK_DECOMPRESSOR_MACROS_SVH

// Check that a condition implies a same-cycle consequence.
`define SBD_ASSERT_IMPL(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error(msg);

// Check that a condition implies a next-cycle consequence.
`define SBD_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error(msg);

`endif

@@ rtl/sbd_pkg.sv @@
// Shared types and constants for the Snappy block decompressor.
// No dependencies.
package sbd_pkg;

  localparam int unsigned HistDepthDef = 65536;
  localparam logic [30:0] MaxLen = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_HDR   = 4'd1,
    ST_HDR_CAP   = 4'd2,
    ST_BAD_TAG   = 4'd3,
    ST_BAD_LIT   = 4'd4,
    ST_BAD_OFF   = 4'd5,
    ST_COPY_CAP  = 4'd6,
    ST_LEN_MIS   = 4'd7,
    ST_TRUNC     = 4'd8
  } status_e;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_TAG     = 7'b0000010,
    PH_LITLEN  = 7'b0000100,
    PH_LITDATA = 7'b0001000,
    PH_COPYOFF = 7'b0010000,
    PH_DRAIN   = 7'b0100000,
    PH_COPY    = 7'b1000000
  } phase_e;

  // Write request into the history store.
  typedef struct packed {
    logic        we;
    logic [19:0] addr;
    logic [7:0]  data;
  } hist_wr_t;

endpackage

@@ rtl/sbd_history.sv @@
// History store: synchronous RAM with one write and one registered read.
// Depends on sbd_pkg.
module sbd_history #(
  parameter int unsigned Depth = sbd_pkg::HistDepthDef
) (
  input  logic                     clk_i,
  input  sbd_pkg::hist_wr_t        wr_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);
  import sbd_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  logic [7:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule

@@ rtl/snappy_block_decompressor.sv @@
// Snappy block decompressor top level: parser, copy engine, output stage.
// Depends on sbd_pkg, sbd_history and the macros header.
//
// Usage: compressed bytes enter on in_byte_i/in_last_i with in_valid/in_ready.
// Decoded bytes leave on out_byte_o with out_valid/out_ready, one per beat;
// the beat with out_last_o set carries status_code_o. If the block's last
// input beat decodes no byte, a status-only beat (byte_valid_o low) is sent.
// A literal byte leaves one beat, registered in the cycle after the byte is
// taken. A copy stalls intake until its last byte is emitted: the history
// RAM has a registered read, and each copied byte is read from the RAM while
// the previous one is written, with forwarding when the offset is 1.
// Reset clears all control state and sets out_capacity to 0x7FFFFFFF; the
// history RAM is not cleared (copies read only bytes of the current block).
// When the receiver stalls, the single output register holds and intake or
// the copy engine pauses until the beat is taken.
// The capacity register is written on cfg_valid/cfg_ready and is always ready.
module snappy_block_decompressor #(
  parameter int unsigned HistoryDepth = sbd_pkg::HistDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] out_capacity_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [3:0]  status_code_o,
  output logic        out_last_o
);
  import sbd_pkg::*;
`include "snappy_block_decompressor_macros.svh"

  localparam int unsigned AW = $clog2(HistoryDepth);

  // Configuration register.
  logic [30:0] cap_q;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= MaxLen;
    end else if (cfg_valid) begin
      cap_q <= out_capacity_i;
    end
  end

  // Block state.
  phase_e      phase_q, phase_d;
  logic [30:0] wcnt_q, wcnt_d, elen_q, elen_d;
  logic [30:0] vacc_q, vacc_d;
  logic        vbig_q, vbig_d;
  logic [6:0]  vsh_q, vsh_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  fleft_q, fleft_d;
  logic [31:0] facc_q, facc_d;
  logic [31:0] lleft_q, lleft_d;
  logic [3:0]  err_q, err_d;
  // Copy engine.
  logic [6:0]  clen_q, clen_d;
  logic [15:0] coff_q, coff_d;
  logic        crd_q, crd_d;   // a read is in flight
  logic        clast_q, clast_d;
  logic [7:0]  prev_q, prev_d;   // last written byte, for offset-1 forwarding
  // Output register.
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        obv_q, obv_d;
  logic [3:0]  ost_q, ost_d;
  logic        ol_q, ol_d;

  hist_wr_t          hwr;
  logic [AW-1:0]     hrd_addr;
  logic [7:0]        hrd_data;

  sbd_history #(.Depth(HistoryDepth)) u_hist (
    .clk_i    (clk_i),
    .wr_i     (hwr),
    .rd_addr_i(hrd_addr),
    .rd_data_o(hrd_data)
  );

  logic        out_free;
  logic        acc;
  logic [30:0] room;
  assign out_free = !ov_q || out_ready;
  assign in_ready = out_free && (phase_q != PH_COPY);
  assign acc      = in_valid && in_ready;
  assign room     = (wcnt_q >= cap_q) ? 31'd0 : cap_q - wcnt_q;

  // Final status given the phase after this beat.
  function automatic logic [3:0] fin_status(phase_e ph, logic [3:0] er,
                                            logic [30:0] wc, logic [30:0] el);
    logic [3:0] s;
    if (er != ST_OK) s = er;
    else if (ph == PH_HEADER) s = ST_BAD_HDR;
    else if (ph == PH_LITLEN || ph == PH_COPYOFF) s = ST_TRUNC;
    else if (ph == PH_LITDATA) s = ST_BAD_LIT;
    else if (wc != el) s = ST_LEN_MIS;
    else s = ST_OK;
    return s;
  endfunction

  logic [31:0] gath;
  logic [2:0]  got;
  logic [31:0] lit_len;
  logic [15:0] off;
  logic [6:0]  len;
  logic        emit_b;
  logic [7:0]  emit_v;
  logic        fin;
  logic [63:0] vsum;
  logic [7:0]  cbyte;

  always_comb begin
    phase_d = phase_q; wcnt_d = wcnt_q; elen_d = elen_q; vacc_d = vacc_q;
    vbig_d = vbig_q; vsh_d = vsh_q; tag_d = tag_q; fleft_d = fleft_q;
    facc_d = facc_q; lleft_d = lleft_q; err_d = err_q; clen_d = clen_q;
    coff_d = coff_q; crd_d = 1'b0; clast_d = clast_q; prev_d = prev_q;
    ov_d = ov_q && !out_ready; ob_d = ob_q; obv_d = obv_q; ost_d = ost_q;
    ol_d = ol_q;
    hwr = '0;
    hrd_addr = AW'(wcnt_q - 31'(coff_q));
    emit_b = 1'b0; emit_v = in_byte_i; fin = 1'b0;
    gath = '0; got = '0; lit_len = '0; off = '0; len = '0; vsum = '0;
    cbyte = (coff_q == 16'd1) ? prev_q : hrd_data;

    if (phase_q == PH_COPY) begin
      // Emit one copied byte per cycle while the output is free, once the read data is back.
      if (crd_q && out_free) begin
        emit_b = 1'b1; emit_v = cbyte;
        fin = (clen_q == 7'd1) && clast_q;
        clen_d = clen_q - 7'd1;
        if (clen_q == 7'd1) phase_d = PH_TAG;
        else begin
          crd_d = 1'b1;
          hrd_addr = AW'(wcnt_q + 31'd1 - 31'(coff_q));
        end
      end else if (!crd_q) begin
        crd_d = 1'b1;
      end else begin
        crd_d = 1'b1;
        hrd_addr = AW'(wcnt_q - 31'(coff_q));
      end
    end else if (acc) begin
      case (phase_q)
        PH_HEADER: begin
          if (vsh_q > 7'd63 || (vsh_q == 7'd63 && in_byte_i > 8'd1)) begin
            err_d = ST_BAD_HDR; phase_d = PH_DRAIN;
          end else if (!in_byte_i[7]) begin
            vsum = 64'(in_byte_i) << vsh_q[5:0];
            if (vbig_q || vsum[63:31] != '0) begin
              err_d = ST_BAD_HDR; phase_d = PH_DRAIN;
            end else if ((vacc_q | vsum[30:0]) > cap_q) begin
              err_d = ST_HDR_CAP; phase_d = PH_DRAIN;
            end else begin
              elen_d = vacc_q | vsum[30:0]; phase_d = PH_TAG;
            end
          end else begin
            vsum = 64'(in_byte_i[6:0]) << vsh_q[5:0];
            vacc_d = vacc_q | vsum[30:0];
            vbig_d = vbig_q || (vsum[63:31] != '0);
            vsh_d = vsh_q + 7'd7;
          end
        end
        PH_TAG: begin
          tag_d = in_byte_i; facc_d = '0;
          case (in_byte_i[1:0])
            2'd0: begin
              if (in_byte_i[7:2] < 6'd60) begin
                lit_len = 32'(in_byte_i[7:2]) + 32'd1;
                if (lit_len > 32'(room)) begin
                  err_d = ST_BAD_LIT; phase_d = PH_DRAIN;
                end else begin
                  lleft_d = lit_len; phase_d = PH_LITDATA;
                end
              end else begin
                fleft_d = 3'(in_byte_i[7:2] - 6'd59); phase_d = PH_LITLEN;
              end
            end
            2'd1: begin fleft_d = 3'd1; phase_d = PH_COPYOFF; end
            2'd2: begin fleft_d = 3'd2; phase_d = PH_COPYOFF; end
            default: begin err_d = ST_BAD_TAG; phase_d = PH_DRAIN; end
          endcase
        end
        PH_LITLEN: begin
          got = 3'(3'(tag_q[7:2] - 6'd59) - fleft_q);
          gath = facc_q | (32'(in_byte_i) << {got[1:0], 3'b000});
          facc_d = gath;
          fleft_d = fleft_q - 3'd1;
          if (fleft_q == 3'd1) begin
            if (gath[31] || gath[30:0] == MaxLen || gath + 32'd1 > 32'(room)) begin
              err_d = ST_BAD_LIT; phase_d = PH_DRAIN;
            end else begin
              lleft_d = gath + 32'd1; phase_d = PH_LITDATA;
            end
          end
        end
        PH_LITDATA: begin
          emit_b = 1'b1;
          lleft_d = lleft_q - 32'd1;
          if (lleft_q == 32'd1) phase_d = PH_TAG;
        end
        PH_COPYOFF: begin
          if (tag_q[1:0] == 2'd1) begin
            off = {5'd0, tag_q[7:5], in_byte_i};
            len = 7'd4 + 7'(tag_q[4:2]);
          end else begin
            got = 3'd2 - fleft_q;
            gath = facc_q | (32'(in_byte_i) << {got[1:0], 3'b000});
            facc_d = gath;
            fleft_d = fleft_q - 3'd1;
            off = gath[15:0];
            len = 7'd1 + 7'(tag_q[7:2]);
          end
          if (tag_q[1:0] == 2'd1 || fleft_q == 3'd1) begin
            fleft_d = 3'd0;
            if (off == 16'd0 || 31'(off) > wcnt_q) begin
              err_d = ST_BAD_OFF; phase_d = PH_DRAIN;
            end else if (31'(len) > room) begin
              err_d = ST_COPY_CAP; phase_d = PH_DRAIN;
            end else begin
              coff_d = off; clen_d = len; clast_d = in_last_i;
              phase_d = PH_COPY; crd_d = 1'b1;
              hrd_addr = AW'(wcnt_q - 31'(off));
            end
          end
        end
        default: ;
      endcase
      // Status-only beat or status on a literal byte; copies finish later.
      if (in_last_i && phase_d != PH_COPY) begin
        fin = 1'b1;
        if (!emit_b) begin
          ov_d = 1'b1; ob_d = 8'd0; obv_d = 1'b0; ol_d = 1'b1;
          ost_d = fin_status(phase_d, err_d, wcnt_q, elen_d);
        end
      end
    end

    // Write a decoded byte into history and the output register.
    if (emit_b) begin
      hwr.we = 1'b1; hwr.addr = 20'(wcnt_q[AW-1:0]); hwr.data = emit_v;
      prev_d = emit_v;
      wcnt_d = wcnt_q + 31'd1;
      ov_d = 1'b1; ob_d = emit_v; obv_d = 1'b1; ol_d = fin;
      ost_d = fin ? fin_status(phase_d, err_d, wcnt_d, elen_d) : ST_OK;
    end

    // Clear block state after the final beat.
    if (fin) begin
      phase_d = PH_HEADER; wcnt_d = '0; elen_d = '0; vacc_d = '0; vbig_d = 1'b0;
      vsh_d = '0; tag_d = '0; fleft_d = '0; facc_d = '0; lleft_d = '0;
      err_d = ST_OK; clast_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; wcnt_q <= '0; elen_q <= '0; vacc_q <= '0;
      vbig_q <= 1'b0; vsh_q <= '0; tag_q <= '0; fleft_q <= '0; facc_q <= '0;
      lleft_q <= '0; err_q <= ST_OK; clen_q <= '0; coff_q <= '0;
      crd_q <= 1'b0; clast_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; wcnt_q <= wcnt_d; elen_q <= elen_d; vacc_q <= vacc_d;
      vbig_q <= vbig_d; vsh_q <= vsh_d; tag_q <= tag_d; fleft_q <= fleft_d;
      facc_q <= facc_d; lleft_q <= lleft_d; err_q <= err_d; clen_q <= clen_d;
      coff_q <= coff_d; crd_q <= crd_d; clast_q <= clast_d; ov_q <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; ob_q <= ob_d; obv_q <= obv_d; ost_q <= ost_d; ol_q <= ol_d;
  end

  assign out_valid     = ov_q;
  assign out_byte_o    = ob_q;
  assign byte_valid_o  = obv_q;
  assign status_code_o = ost_q;
  assign out_last_o    = ol_q;

  `SBD_ASSERT_IMPL(a_no_intake_in_copy, clk_i, rst_ni,
    phase_q == PH_COPY, !in_ready, "intake open during copy")
  `SBD_ASSERT_IMPL(a_status_only_last, clk_i, rst_ni,
    out_valid && !byte_valid_o, out_last_o, "status-only beat without last")
  `SBD_ASSERT_IMPL(a_copy_len_nonzero, clk_i, rst_ni,
    phase_q == PH_COPY, clen_q != 7'd0, "copy with zero length")
  `SBD_ASSERT_NEXT(a_last_clears, clk_i, rst_ni,
    out_valid && out_ready && out_last_o && !ov_d, !out_valid,
    "stale beat after last")
endmodule

@@ tb/tb_snappy_block_decompressor.sv @@
// Testbench for the Snappy block decompressor: directed table plus random blocks,
// with an in-bench decoder model and a scoreboard of expected output beats.
// Depends on sbd_pkg and the snappy_block_decompressor RTL.
`timescale 1ns / 1ps

module tb_snappy_block_decompressor;
  import sbd_pkg::*;

  typedef struct {
    logic [7:0] ob;
    logic       bv;
    status_e    st;
    logic       lst;
  } beat_t;

  typedef struct {
    logic [7:0] b;
    bit         l;
    bit         pin;
    status_e    st;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] out_capacity_i = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic [3:0]  status_code_o;
  logic        out_last_o;

  snappy_block_decompressor dut (.*);

  always #2 clk_i = ~clk_i;

  // Decoder model state
  logic [7:0]      hist [0:65535];
  logic [30:0]     cap_m;
  int unsigned     written, exp_len, vshift, fleft, lit_left;
  longint unsigned vacc;
  logic [31:0]     facc;
  logic [7:0]      tag_b;
  phase_e          ph;
  status_e         err;

  beat_t       expected_beats [$];
  logic [7:0]  blk_bytes [$];
  int          fails = 0;
  int          beats_seen = 0;
  int          bytes_sent = 0;
  int          blocks_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  row_t dir_rows [23] = '{
    '{8'h00, 1, 1, ST_OK},
    '{8'h80, 1, 1, ST_BAD_HDR},
    '{8'h07, 0, 0, ST_OK}, '{8'h08, 0, 0, ST_OK}, '{8'h00, 0, 0, ST_OK},
    '{8'hFF, 0, 0, ST_OK}, '{8'h41, 0, 0, ST_OK}, '{8'h01, 0, 0, ST_OK},
    '{8'h03, 1, 0, ST_OK},
    '{8'h02, 0, 0, ST_OK}, '{8'h03, 0, 0, ST_OK}, '{8'h55, 1, 1, ST_BAD_TAG},
    '{8'h01, 0, 0, ST_OK}, '{8'h02, 0, 0, ST_OK}, '{8'h00, 0, 0, ST_OK},
    '{8'h00, 1, 1, ST_BAD_OFF},
    '{8'h05, 0, 0, ST_OK}, '{8'hF0, 1, 1, ST_TRUNC},
    '{8'hFF, 0, 0, ST_OK}, '{8'hFF, 0, 0, ST_OK}, '{8'hFF, 0, 0, ST_OK},
    '{8'hFF, 0, 0, ST_OK}, '{8'h08, 1, 1, ST_BAD_HDR}
  };

  task automatic clear_block();
    written = 0; exp_len = 0; vacc = 0; vshift = 0; ph = PH_HEADER;
    tag_b = 0; fleft = 0; facc = 0; lit_left = 0; err = ST_OK;
  endtask

  function automatic int unsigned room();
    return (written >= cap_m) ? 0 : cap_m - written;
  endfunction

  task automatic flag(input status_e code);
    err = code;
    ph = PH_DRAIN;
  endtask

  task automatic emit(ref beat_t got[$], input logic [7:0] b);
    got.push_back('{b, 1'b1, ST_OK, 1'b0});
    hist[written % 65536] = b;
    written++;
  endtask

  task automatic start_literal(input longint unsigned len);
    if (len > MaxLen || len > room()) flag(ST_BAD_LIT);
    else begin
      lit_left = len;
      ph = PH_LITDATA;
    end
  endtask

  task automatic run_copy(ref beat_t got[$], input int unsigned off, input int unsigned len);
    if (off == 0 || off > written) flag(ST_BAD_OFF);
    else if (len > room()) flag(ST_COPY_CAP);
    else begin
      for (int i = 0; i < len; i++) emit(got, hist[(written - off) % 65536]);
      ph = PH_TAG;
    end
  endtask

  task automatic gather(input logic [7:0] b, input int unsigned total);
    int unsigned pos;
    pos = (total - fleft) & 3;
    facc |= 32'(b) << (8 * pos);
    if (fleft > 0) fleft--;
  endtask

  // Advance the decoder by one compressed byte and queue the beats it yields
  task automatic decode_byte(input logic [7:0] b, input bit lst, input bit pin,
                             input status_e pin_st);
    beat_t           got [$];
    longint unsigned v;
    status_e         st;
    case (ph)
      PH_HEADER: begin
        if (vshift > 63 || (vshift == 63 && b > 1)) flag(ST_BAD_HDR);
        else if (!b[7]) begin
          v = vacc | (longint'(b) << vshift);
          if (v > MaxLen) flag(ST_BAD_HDR);
          else if (v > cap_m) flag(ST_HDR_CAP);
          else begin
            exp_len = v;
            ph = PH_TAG;
          end
        end else begin
          vacc |= longint'(b[6:0]) << vshift;
          vshift = (vshift + 7) & 8'h7F;
        end
      end
      PH_TAG: begin
        tag_b = b;
        facc = 0;
        case (b[1:0])
          2'd0: begin
            if (b[7:2] < 60) start_literal(b[7:2] + 1);
            else begin
              fleft = b[7:2] - 59;
              ph = PH_LITLEN;
            end
          end
          2'd1: begin fleft = 1; ph = PH_COPYOFF; end
          2'd2: begin fleft = 2; ph = PH_COPYOFF; end
          default: flag(ST_BAD_TAG);
        endcase
      end
      PH_LITLEN: begin
        gather(b, tag_b[7:2] - 59);
        if (fleft == 0) start_literal(longint'(facc) + 1);
      end
      PH_LITDATA: begin
        emit(got, b);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) ph = PH_TAG;
      end
      PH_COPYOFF: begin
        if (tag_b[1:0] == 2'd1) begin
          gather(b, 1);
          run_copy(got, (32'(tag_b[7:5]) << 8) | facc, 4 + tag_b[4:2]);
        end else begin
          gather(b, 2);
          if (fleft == 0) run_copy(got, facc, 1 + tag_b[7:2]);
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (err != ST_OK) st = err;
      else if (ph == PH_HEADER) st = ST_BAD_HDR;
      else if (ph == PH_LITLEN || ph == PH_COPYOFF) st = ST_TRUNC;
      else if (ph == PH_LITDATA) st = ST_BAD_LIT;
      else if (written != exp_len) st = ST_LEN_MIS;
      else st = ST_OK;
      if (got.size() == 0) got.push_back('{8'h00, 1'b0, ST_OK, 1'b0});
      got[$].st = st;
      got[$].lst = 1'b1;
      clear_block();
    end
    // Pinned rows carry a status-only final beat read straight off the spec
    if (pin) begin
      got.delete();
      got.push_back('{8'h00, 1'b0, pin_st, 1'b1});
    end
    foreach (got[i]) expected_beats.push_back(got[i]);
  endtask

  // Offer one byte; hold valid and payload until the beat is taken
  task automatic send_byte(input logic [7:0] b, input bit lst, input bit pin,
                           input status_e pin_st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_byte_i <= b;
    in_last_i <= lst;
    do @(posedge clk_i); while (!in_ready);
    decode_byte(b, lst, pin, pin_st);
    bytes_sent++;
    if (lst) blocks_sent++;
  endtask

  task automatic push_varint(input int unsigned v);
    while (v >= 128) begin
      blk_bytes.push_back(8'(v | 8'h80));
      v = v >> 7;
    end
    blk_bytes.push_back(8'(v));
  endtask

  // Build a block: mostly well formed with random content, some damaged or noise
  task automatic build_block();
    logic [7:0]  body [$];
    int unsigned w, len, off, nb, kind, mode, nops;
    w = 0;
    blk_bytes.delete();
    mode = $urandom_range(9);
    nops = $urandom_range(1, 3);
    for (int k = 0; k < nops; k++) begin
      kind = (w == 0) ? 0 : $urandom_range(2);
      if (kind == 0) begin
        len = ($urandom_range(7) == 0) ? 60 : $urandom_range(1, 12);
        if ($urandom_range(3) == 0) body.push_back(8'((len - 1) << 2));
        else begin
          nb = $urandom_range(1, 4);
          body.push_back(8'((59 + nb) << 2));
          for (int i = 0; i < nb; i++) body.push_back(8'((len - 1) >> (8 * i)));
        end
        for (int i = 0; i < len; i++) body.push_back(8'($urandom));
      end else if (kind == 1) begin
        len = $urandom_range(4, 11);
        off = $urandom_range(1, (w > 2047) ? 2047 : w);
        body.push_back(8'(((off >> 8) << 5) | ((len - 4) << 2) | 1));
        body.push_back(8'(off));
      end else begin
        len = ($urandom_range(5) == 0) ? 64 : $urandom_range(1, 16);
        off = $urandom_range(1, w);
        body.push_back(8'(((len - 1) << 2) | 2));
        body.push_back(8'(off));
        body.push_back(8'(off >> 8));
      end
      w += len;
    end
    push_varint((mode == 7) ? w + $urandom_range(1, 3) : w);
    foreach (body[i]) blk_bytes.push_back(body[i]);
    if (mode == 6) repeat ($urandom_range(1, 3))
      if (blk_bytes.size() > 1) void'(blk_bytes.pop_back());
    if (mode == 8) blk_bytes[$urandom_range(blk_bytes.size() - 1)] = 8'($urandom);
    if (mode == 9) begin
      blk_bytes.delete();
      repeat ($urandom_range(1, 12)) blk_bytes.push_back(8'($urandom));
    end
  endtask

  // Write the capacity register once the block is idle
  task automatic write_capacity(input logic [30:0] value);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    cfg_valid      <= 1'b1;
    out_capacity_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_m = value;
  endtask

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        fails++;
        $display("%0t: unexpected beat byte=%h bv=%b st=%0d last=%b", $time,
                 out_byte_o, byte_valid_o, status_code_o, out_last_o);
      end else begin
        e = expected_beats.pop_front();
        if (out_byte_o !== e.ob || byte_valid_o !== e.bv || status_code_o !== e.st ||
            out_last_o !== e.lst) begin
          fails++;
          $display("%0t: mismatch expected byte=%h bv=%b st=%0d last=%b, got byte=%h bv=%b st=%0d last=%b",
                   $time, e.ob, e.bv, e.st, e.lst,
                   out_byte_o, byte_valid_o, status_code_o, out_last_o);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  logic [30:0] caps [4];
  int          send_pcts [4] = '{0, 77, 0, 29};
  int          recv_pcts [4] = '{0, 0, 77, 29};

  initial begin
    int phase_bytes;
    for (int i = 0; i < 65536; i++) hist[i] = 8'h00;
    cap_m = MaxLen;
    clear_block();
    caps = '{MaxLen, 31'd0, 31'd20, 31'($urandom_range(24, 200))};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, dir_rows[i].st);
    in_valid <= 1'b0;

    // Random blocks over capacity settings and idle patterns
    for (int p = 0; p < 4; p++) begin
      write_capacity(caps[p]);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 0) hold_left = 300;
      phase_bytes = 0;
      while (phase_bytes < 12) begin
        build_block();
        foreach (blk_bytes[i])
          send_byte(blk_bytes[i], i == blk_bytes.size() - 1, 1'b0, ST_OK);
        phase_bytes += blk_bytes.size();
      end
      in_valid <= 1'b0;
    end

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Sent %0d bytes in %0d blocks, checked %0d output beats", bytes_sent,
             blocks_sent, beats_seen);
    $display("Capacity settings: max, zero, 20, %0d; four idle patterns", caps[3]);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
